>>> rtl/tkvs_pkg.sv
// ----------------------------------------------------------------------------
// tkvs_pkg: shared types and codes for the timestamped key-value store
// Field widths, result status codes, request kinds and the history entry.
// ----------------------------------------------------------------------------
package tkvs_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int TS_W  = 31;
  localparam int ST_W  = 2;

  // request kinds
  localparam logic KIND_SET = 1'b0;
  localparam logic KIND_GET = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS    = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_SLOT = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  // one history entry as held in the entry memory
  typedef struct packed {
    logic [TS_W-1:0]  ts;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

>>> rtl/tkvs_if.sv
// ----------------------------------------------------------------------------
// tkvs_if: request and response channels of the key-value store
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tkvs_req_if
  import tkvs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  logic [TS_W-1:0]  timestamp;

  modport source (output valid, kind, key, value, timestamp, input ready);
  modport sink   (input valid, kind, key, value, timestamp, output ready);
endinterface

interface tkvs_rsp_if
  import tkvs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [VAL_W-1:0] result_value;

  modport source (output valid, status, result_value, input ready);
  modport sink   (input valid, status, result_value, output ready);
endinterface

>>> rtl/tkvs_hist_mem.sv
// ----------------------------------------------------------------------------
// tkvs_hist_mem: single-port history entry memory
// One access per cycle: write, or read with registered read data.
// ----------------------------------------------------------------------------
module tkvs_hist_mem
  import tkvs_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  entry_t            wdata,
  output entry_t            rdata
);

  entry_t mem [DEPTH];

  // write port and registered read port share the address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/timestamped_key_value_store_core.sv
// ----------------------------------------------------------------------------
// timestamped_key_value_store_core: versioned key-value store
// Each key owns a history of (timestamp, value) pairs in one key slot.
//
// Usage:
//   in_req  : set (kind 0) appends (timestamp, value) to key's history,
//             claiming the lowest free slot for a new key; get (kind 1)
//             returns the value of the latest entry with timestamp <= target.
//   out_rsp : one response per request: status and result_value.
// Flow: all slot keys are compared at once, then one shared memory port
//   and one compare unit run a binary search, each probe an address step
//   (RD) and then a compare step (CMP) on the registered read data.
//   A request passes MATCH, RESOLVE and ACT; a set, or a get of an unknown
//   key, then goes to DONE, while a get of a known key probes until its
//   window is empty. The response is loaded into the output register from
//   DONE, and the next request is taken only back in IDLE. A get makes
//   k probes, k <= floor(log2(HISTORY_DEPTH))+1.
// Reset: slot valid bits and history counts clear at once; the entry
//   memory is not cleared (entries are read only below a slot's count).
// Stall: the response sits in an output register; one new request may be
//   taken and worked on meanwhile, and the finished response of that one
//   waits until the output register is free.
// ----------------------------------------------------------------------------
module timestamped_key_value_store_core
  import tkvs_pkg::*;
#(
  parameter int KEY_SLOTS     = 16,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  tkvs_req_if.sink   in_req,
  tkvs_rsp_if.source out_rsp
);

  localparam int SLOT_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int TOTAL   = KEY_SLOTS * HISTORY_DEPTH;
  localparam int ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MATCH   = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_ACT     = 3'd3;
  localparam logic [2:0] S_RD      = 3'd4;
  localparam logic [2:0] S_CMP     = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]             state_r, state_nxt;

  // latched request
  logic                   kind_r;
  logic [KEY_W-1:0]       key_r;
  logic [VAL_W-1:0]       val_r;
  logic [TS_W-1:0]        ts_r;

  // key slots
  logic [KEY_SLOTS-1:0]   slot_valid_r;
  logic [KEY_W-1:0]       slot_key_r [KEY_SLOTS];
  logic [CNT_W-1:0]       hist_cnt_r [KEY_SLOTS];
  logic [KEY_SLOTS-1:0]   hit_r, free_r;

  // resolved slot
  logic [SLOT_W-1:0]      slot_r;
  logic                   slot_ok_r;
  logic                   slot_new_r;
  logic [SLOT_W-1:0]      hit_idx, free_idx;

  // search registers
  logic [CNT_W-1:0]       lo_r, hi_r, mid_r;
  logic [CNT_W-1:0]       mid;
  logic                   found_r;
  logic [VAL_W-1:0]       best_r;

  // result staging and output register
  logic [ST_W-1:0]        res_status_r;
  logic [VAL_W-1:0]       res_val_r;
  logic                   out_valid_r;
  logic [ST_W-1:0]        out_status_r;
  logic [VAL_W-1:0]       out_val_r;

  // memory port
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_addr;
  logic [ADDR_W-1:0]      slot_base;
  logic [CNT_W-1:0]       cur_cnt;
  entry_t                 mem_wdata, mem_rdata;

  logic                   req_take;
  logic                   out_free;

  assign req_take = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.result_value = out_val_r;

  // first hit and first free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (free_r[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  // history base of the resolved slot and its count
  assign slot_base = ADDR_W'(slot_r) * ADDR_W'(HISTORY_DEPTH);
  assign cur_cnt   = hist_cnt_r[slot_r];

  // probe index: lower midpoint of [lo, hi)
  assign mid = lo_r + ((hi_r - lo_r - CNT_W'(1)) >> 1);

  // memory access: append in ACT, probe in RD
  always_comb begin
    mem_we          = 1'b0;
    mem_addr        = slot_base + ADDR_W'(mid);
    mem_wdata.ts    = ts_r;
    mem_wdata.value = val_r;
    if (state_r == S_ACT) begin
      mem_addr = slot_base + ADDR_W'(cur_cnt);
      mem_we   = slot_ok_r && (kind_r == KIND_SET) &&
                 (cur_cnt < CNT_W'(HISTORY_DEPTH));
    end
  end

  tkvs_hist_mem #(
    .DEPTH  (TOTAL),
    .ADDR_W (ADDR_W)
  ) u_hist_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (req_take) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH:   state_nxt = S_RESOLVE;
      S_RESOLVE: state_nxt = S_ACT;
      S_ACT: begin
        if (slot_ok_r && kind_r == KIND_GET) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        if (lo_r < hi_r) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CMP:     state_nxt = S_RD;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      slot_valid_r <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        hist_cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // output register
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      // append bookkeeping
      if (mem_we) begin
        hist_cnt_r[slot_r] <= cur_cnt + CNT_W'(1);
        if (slot_new_r) begin
          slot_valid_r[slot_r] <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // request latch
    if (req_take) begin
      kind_r <= in_req.kind;
      key_r  <= in_req.key;
      val_r  <= in_req.value;
      ts_r   <= in_req.timestamp;
    end
    // claim key word for a new slot
    if (mem_we && slot_new_r) begin
      slot_key_r[slot_r] <= key_r;
    end
    // associative match over all slots
    if (state_r == S_MATCH) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        hit_r[i]  <= slot_valid_r[i] && (slot_key_r[i] == key_r);
        free_r[i] <= !slot_valid_r[i];
      end
    end
    // pick the slot
    if (state_r == S_RESOLVE) begin
      if (|hit_r) begin
        slot_r     <= hit_idx;
        slot_ok_r  <= 1'b1;
        slot_new_r <= 1'b0;
      end else if (kind_r == KIND_SET && |free_r) begin
        slot_r     <= free_idx;
        slot_ok_r  <= 1'b1;
        slot_new_r <= 1'b1;
      end else begin
        slot_r     <= '0;
        slot_ok_r  <= 1'b0;
        slot_new_r <= 1'b0;
      end
    end
    // append or start the search
    if (state_r == S_ACT) begin
      lo_r      <= '0;
      hi_r      <= cur_cnt;
      found_r   <= 1'b0;
      best_r    <= '0;
      res_val_r <= '0;
      if (!slot_ok_r) begin
        res_status_r <= (kind_r == KIND_GET) ? ST_MISS : ST_NO_SLOT;
      end else if (kind_r == KIND_SET) begin
        res_status_r <= (cur_cnt < CNT_W'(HISTORY_DEPTH)) ? ST_OK : ST_FULL;
      end
    end
    // probe or finish the search
    if (state_r == S_RD) begin
      mid_r <= mid;
      if (!(lo_r < hi_r)) begin
        res_status_r <= found_r ? ST_OK : ST_MISS;
        res_val_r    <= found_r ? best_r : '0;
      end
    end
    // compare the probed entry
    if (state_r == S_CMP) begin
      if (mem_rdata.ts <= ts_r) begin
        found_r <= 1'b1;
        best_r  <= mem_rdata.value;
        lo_r    <= mid_r + CNT_W'(1);
      end else begin
        hi_r    <= mid_r;
      end
    end
    // output payload
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_val_r    <= res_val_r;
    end
  end

  // a key may live in one slot only
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESOLVE |-> $onehot0(hit_r))
    else $error("key matches more than one slot");

  // histories never grow past their depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACT |-> cur_cnt <= CNT_W'(HISTORY_DEPTH))
    else $error("history count beyond depth");

  // appends happen only for a set in the action step
  a_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_ACT && kind_r == KIND_SET && slot_ok_r))
    else $error("entry write outside a set");

  // search window stays ordered
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_CMP) |-> lo_r <= hi_r)
    else $error("search window inverted");

  // a taken request starts the slot match
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |=> state_r == S_MATCH)
    else $error("request not started");

endmodule
